// ----- rtl/ssw_pkg.sv -----
// Shared types and constants for the SMBIOS structure walker.
`timescale 1ns / 1ps
package ssw_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int FIELD_OFS_W = 16;
	localparam int EXT_W       = (OFFSET_BITS > FIELD_OFS_W) ? OFFSET_BITS : FIELD_OFS_W;
	localparam int CNT_W       = 16;
	localparam int CNT_XW      = CNT_W + 1;
	localparam int Q_DEPTH     = 2;
	localparam int Q_AW        = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CW        = $clog2(Q_DEPTH + 1);
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	localparam logic [7:0] MIN_HEADER = 8'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TYPE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_TYPE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_FIRST   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_START_OFFSET = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LENGTH = 3'd4;

	typedef logic [OFFSET_BITS-1:0] offset_t;

	typedef enum logic [1:0] {
		PH_TYPE,
		PH_LEN,
		PH_FORMATTED,
		PH_STRINGS
	} ssw_phase_t;

	typedef struct packed {
		logic [7:0]  target_type;
		logic        ignore_type;
		logic        skip_first;
		logic [15:0] start_offset;
		logic [15:0] table_length;
	} ssw_cfg_t;

	// one classified byte travelling from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       in_table;
		logic       is_zero;
		logic       is_short;
		offset_t    here;
	} ssw_item_t;

endpackage

// ----- rtl/ssw_front.sv -----
// Front end: accepts bytes, tracks the table offset and classifies each byte.
`timescale 1ns / 1ps
module ssw_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	input  ssw_pkg::ssw_cfg_t    cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output ssw_pkg::ssw_item_t   push_item
);
	import ssw_pkg::*;

	offset_t offset_q;
	offset_t base;
	offset_t bump;
	logic    accept;

	assign in_ready   = push_ready;
	assign push_valid = in_valid;
	assign accept     = in_valid && push_ready;

	// a new walk restarts counting at the configured start offset
	assign base = first_byte ? OFFSET_BITS'(cfg.start_offset) : offset_q;
	assign bump = (base == '1) ? base : base + 1'b1;

	always_comb begin
		push_item.data     = data_byte;
		push_item.first    = first_byte;
		push_item.in_table = EXT_W'(base) < EXT_W'(cfg.table_length);
		push_item.is_zero  = (data_byte == 8'd0);
		push_item.is_short = (data_byte < MIN_HEADER);
		push_item.here     = base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (accept) begin
			offset_q <= bump;
		end
	end

endmodule

// ----- rtl/ssw_queue.sv -----
// Small first-word-fall-through queue between front and back.
`timescale 1ns / 1ps
module ssw_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  ssw_pkg::ssw_item_t   push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output ssw_pkg::ssw_item_t   pop_item
);
	import ssw_pkg::*;

	ssw_item_t           mem_q [Q_DEPTH];
	logic [Q_AW-1:0]     wr_ptr_q;
	logic [Q_AW-1:0]     rd_ptr_q;
	logic [Q_CW-1:0]     count_q;
	logic                push;
	logic                pop;

	assign push_ready = (count_q != Q_CW'(Q_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/ssw_back.sv -----
// Back end: structure parse state machine and output register.
`timescale 1ns / 1ps
module ssw_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  ssw_pkg::ssw_item_t   item,
	input  ssw_pkg::ssw_cfg_t    cfg,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           struct_type,
	output logic [15:0]          struct_offset,
	output logic [15:0]          struct_size,
	output logic                 type_matched,
	output logic                 short_header
);
	import ssw_pkg::*;

	ssw_phase_t        phase_q, n_phase;
	offset_t           start_q, n_start;
	logic [7:0]        fl_q, n_fl;
	logic [CNT_W-1:0]  bytes_q, n_bytes, bytes_inc;
	logic [7:0]        type_q, n_type;
	logic              lwz_q, n_lwz;
	logic              skip_q, n_skip;
	logic              short_q, n_short;
	logic              emit;
	logic              match;
	logic              pop;
	logic              out_valid_q;
	logic [EXT_W-1:0]  start_ext;

	assign pop       = pop_valid && pop_ready;
	assign pop_ready = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign bytes_inc = (bytes_q == '1) ? bytes_q : bytes_q + 1'b1;
	assign start_ext = EXT_W'(start_q);

	always_comb begin
		n_phase = phase_q;
		n_start = start_q;
		n_fl    = fl_q;
		n_bytes = bytes_q;
		n_type  = type_q;
		n_lwz   = lwz_q;
		n_skip  = skip_q;
		n_short = short_q;
		emit    = 1'b0;
		match   = 1'b0;
		if (item.first) begin
			n_phase = PH_TYPE;
			n_start = '0;
			n_fl    = '0;
			n_bytes = '0;
			n_type  = '0;
			n_lwz   = 1'b0;
			n_short = 1'b0;
			n_skip  = cfg.skip_first;
		end
		// bytes past the table end leave the parse untouched, though a first byte still restarts it
		if (item.in_table) begin
			case (n_phase)
				PH_TYPE: begin
					n_type  = item.data;
					n_start = item.here;
					n_bytes = CNT_W'(1);
					n_phase = PH_LEN;
				end
				PH_LEN: begin
					n_short = item.is_short;
					n_fl    = item.is_short ? MIN_HEADER : item.data;
					n_bytes = CNT_W'(2);
					n_phase = PH_FORMATTED;
				end
				PH_FORMATTED: begin
					if (({1'b0, bytes_q} + CNT_XW'(1)) >= CNT_XW'(fl_q)) begin
						n_phase = PH_STRINGS;
						n_lwz   = 1'b0;
					end
					n_bytes = bytes_inc;
				end
				PH_STRINGS: begin
					if (item.is_zero && lwz_q) begin
						emit    = 1'b1;
						match   = (cfg.ignore_type || type_q == cfg.target_type) && !skip_q;
						n_skip  = 1'b0;
						n_phase = PH_TYPE;
						n_start = '0;
						n_fl    = '0;
						n_bytes = '0;
						n_type  = '0;
						n_lwz   = 1'b0;
						n_short = 1'b0;
					end else begin
						n_lwz   = item.is_zero;
						n_bytes = bytes_inc;
					end
				end
				default: begin
					n_phase = PH_TYPE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			start_q <= '0;
			fl_q    <= '0;
			bytes_q <= '0;
			type_q  <= '0;
			lwz_q   <= 1'b0;
			skip_q  <= 1'b0;
			short_q <= 1'b0;
		end else if (pop) begin
			phase_q <= n_phase;
			start_q <= n_start;
			fl_q    <= n_fl;
			bytes_q <= n_bytes;
			type_q  <= n_type;
			lwz_q   <= n_lwz;
			skip_q  <= n_skip;
			short_q <= n_short;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			struct_type   <= type_q;
			struct_offset <= start_ext[FIELD_OFS_W-1:0];
			struct_size   <= bytes_q;
			type_matched  <= match;
			short_header  <= short_q;
		end
	end

endmodule

// ----- rtl/smbios_structure_walker_unit.sv -----
// Top level of the SMBIOS structure walker: config registers, front, queue, back.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) takes one table byte per transaction with
//   first_byte marking the start of a walk. Output channel (out_valid/out_ready)
//   delivers one transaction per structure, when the second zero of its
//   terminating zero pair arrives.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
//   write registers only while the block is idle.
//   Throughput: one byte per cycle while no result is held, set by the parse state
//   machine in the back end, which handles each byte as it is popped. Path: the
//   accepting edge writes the byte that ends the structure into the queue; the back
//   end then pops it and parses it into the output register, which raises out_valid.
//   Stall: while out_valid is held without out_ready the back end stops
//   popping; the two-entry queue fills and then in_ready drops.
//   Reset: control registers clear (not queue storage or output fields), the parse
//   waits for a type byte at offset zero and no structure is skipped. No clearing pass is needed.
module smbios_structure_walker_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        data_byte,
	input  logic                              first_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        struct_type,
	output logic [15:0]                       struct_offset,
	output logic [15:0]                       struct_size,
	output logic                              type_matched,
	output logic                              short_header,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ssw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ssw_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import ssw_pkg::*;

	ssw_cfg_t  cfg_q;
	ssw_item_t push_item;
	ssw_item_t pop_item;
	logic      push_valid;
	logic      push_ready;
	logic      pop_valid;
	logic      pop_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_TARGET_TYPE:  cfg_q.target_type  <= cfg_data[7:0];
				CFG_IGNORE_TYPE:  cfg_q.ignore_type  <= cfg_data[0];
				CFG_SKIP_FIRST:   cfg_q.skip_first   <= cfg_data[0];
				CFG_START_OFFSET: cfg_q.start_offset <= cfg_data[15:0];
				CFG_TABLE_LENGTH: cfg_q.table_length <= cfg_data[15:0];
				default:          cfg_q <= cfg_q;
			endcase
		end
	end

	ssw_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.cfg        (cfg_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	ssw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	ssw_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.pop_valid     (pop_valid),
		.pop_ready     (pop_ready),
		.item          (pop_item),
		.cfg           (cfg_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.struct_type   (struct_type),
		.struct_offset (struct_offset),
		.struct_size   (struct_size),
		.type_matched  (type_matched),
		.short_header  (short_header)
	);

`ifndef ASSERT_OFF
	// a full queue is never empty
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> pop_valid)
		else $error("queue refuses input while empty");

	// back end holds while a result is pending
	a_back_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !pop_ready)
		else $error("back end advanced while output stalled");

	// every structure has at least a 4-byte header and a zero before the pair end
	a_min_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (struct_size >= 16'd5))
		else $error("structure size below minimum");
`endif

endmodule

// ----- tb/sv/smbios_walk_checker.sv -----
// Structure-record predictor and scoreboard for the SMBIOS structure walker.
`timescale 1ns / 1ps
module smbios_walk_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           first_byte,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic [7:0]                     struct_type,
	input  logic [15:0]                    struct_offset,
	input  logic [15:0]                    struct_size,
	input  logic                           type_matched,
	input  logic                           short_header,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [ssw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ssw_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             mismatches,
	output int                             records_due
);
	import ssw_pkg::*;

	typedef struct packed {
		logic [7:0]  stype;
		logic [15:0] start;
		logic [15:0] size;
		logic        matched;
		logic        shrt;
	} struct_record_t;

	struct_record_t expected_records[$];

	ssw_cfg_t   regs;
	ssw_phase_t phase;
	offset_t    next_ofs;
	offset_t    struct_start;
	logic [7:0] hdr_len;
	logic [7:0] cur_type;
	logic [15:0] run_len;
	logic       prev_zero;
	logic       skip_armed;
	logic       hdr_short;

	initial begin
		mismatches = 0;
		records_due = 0;
	end

	function void restart_walk();
		phase = PH_TYPE;
		struct_start = '0;
		hdr_len = '0;
		run_len = '0;
		cur_type = '0;
		prev_zero = 1'b0;
		hdr_short = 1'b0;
	endfunction

	function void bump_run();
		if (run_len != 16'hFFFF)
			run_len++;
	endfunction

	function void walk_byte(input logic [7:0] b, input logic first);
		offset_t here;
		struct_record_t rec;
		if (first) begin
			restart_walk();
			next_ofs = offset_t'(regs.start_offset);
			skip_armed = regs.skip_first;
		end
		here = next_ofs;
		if (next_ofs != '1)
			next_ofs++;
		// past the table end: only the offset moves (a first byte has already restarted the walk)
		if (here >= regs.table_length)
			return;
		case (phase)
			PH_TYPE: begin
				cur_type = b;
				struct_start = here;
				run_len = 16'd1;
				phase = PH_LEN;
			end
			PH_LEN: begin
				hdr_short = (b < MIN_HEADER);
				hdr_len = hdr_short ? MIN_HEADER : b;
				run_len = 16'd2;
				phase = PH_FORMATTED;
			end
			PH_FORMATTED: begin
				if (({1'b0, run_len} + 17'd1) >= {9'd0, hdr_len}) begin
					phase = PH_STRINGS;
					prev_zero = 1'b0;
				end
				bump_run();
			end
			default: begin
				if (b == 8'h00 && prev_zero) begin
					rec.stype = cur_type;
					rec.start = 16'(struct_start);
					rec.size = run_len;
					rec.matched = (regs.ignore_type || cur_type == regs.target_type)
						&& !skip_armed;
					rec.shrt = hdr_short;
					expected_records.push_back(rec);
					skip_armed = 1'b0;
					restart_walk();
				end else begin
					prev_zero = (b == 8'h00);
					bump_run();
				end
			end
		endcase
	endfunction

	function void note_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function void check_record();
		struct_record_t want;
		if (expected_records.size() == 0) begin
			$display("%0t: unexpected record type %0h offset %0h size %0h expected none",
				$time, struct_type, struct_offset, struct_size);
			mismatches++;
			return;
		end
		want = expected_records.pop_front();
		note_field("struct_type", 16'(want.stype), 16'(struct_type));
		note_field("struct_offset", want.start, struct_offset);
		note_field("struct_size", want.size, struct_size);
		note_field("type_matched", 16'(want.matched), 16'(type_matched));
		note_field("short_header", 16'(want.shrt), 16'(short_header));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '0;
			next_ofs = '0;
			skip_armed = 1'b0;
			restart_walk();
			expected_records.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TARGET_TYPE:  regs.target_type = cfg_data[7:0];
					CFG_IGNORE_TYPE:  regs.ignore_type = cfg_data[0];
					CFG_SKIP_FIRST:   regs.skip_first = cfg_data[0];
					CFG_START_OFFSET: regs.start_offset = cfg_data[15:0];
					CFG_TABLE_LENGTH: regs.table_length = cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				walk_byte(data_byte, first_byte);
			if (out_valid && out_ready)
				check_record();
		end
		records_due = expected_records.size();
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench top for the SMBIOS structure walker: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
	import ssw_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD   = 400;
	localparam int PHASE_ITEMS = 150;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	logic [7:0]            data_byte;
	logic                  first_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            struct_type;
	logic [15:0]           struct_offset;
	logic [15:0]           struct_size;
	logic                  type_matched;
	logic                  short_header;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int         mismatches;
	int         records_due;
	int         idle_cycles = 0;
	int         bytes_sent;
	bit         sender_steady;
	bit         sink_steady;
	bit         hold_req;
	logic [7:0] target_sel;

	smbios_structure_walker_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.struct_type  (struct_type),
		.struct_offset(struct_offset),
		.struct_size  (struct_size),
		.type_matched (type_matched),
		.short_header (short_header),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	smbios_walk_checker walk_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.first_byte   (first_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.struct_type  (struct_type),
		.struct_offset(struct_offset),
		.struct_size  (struct_size),
		.type_matched (type_matched),
		.short_header (short_header),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.records_due  (records_due)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog: any transaction on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// record sink: random back-pressure, plus one long hold on request
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			stall = sink_steady ? 0 : $urandom_range(0, 8);
			if (hold_req) begin
				hold_req = 1'b0;
				stall = LONG_HOLD;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			@(posedge clk);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic f);
		int gap;
		gap = sender_steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		first_byte <= f;
		@(negedge clk);
		while (!in_ready) @(negedge clk);
		@(posedge clk);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [7:0] tgt, input logic ign, input logic skp,
			input logic [15:0] so, input logic [15:0] tl);
		write_reg(CFG_TARGET_TYPE, {8'd0, tgt});
		write_reg(CFG_IGNORE_TYPE, {15'd0, ign});
		write_reg(CFG_SKIP_FIRST, {15'd0, skp});
		write_reg(CFG_START_OFFSET, so);
		write_reg(CFG_TABLE_LENGTH, tl);
		target_sel = tgt;
	endtask

	// drain all records, then give trailing bytes time to clear the pipeline
	task automatic settle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (records_due != 0) @(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// type, length, formatted body, then strings closed by a zero pair
	task automatic send_struct(input logic [7:0] t, input logic [7:0] len,
			input int strings, input logic f);
		int body;
		int n;
		body = (len < MIN_HEADER) ? 2 : len - 2;
		send_byte(t, f);
		send_byte(len, 1'b0);
		repeat (body) send_byte(8'($urandom), 1'b0);
		repeat (strings) begin
			n = $urandom_range(1, 6);
			repeat (n) send_byte(8'($urandom_range(1, 255)), 1'b0);
			send_byte(8'h00, 1'b0);
		end
		send_byte(8'h00, 1'b0);
		if (strings == 0)
			send_byte(8'h00, 1'b0);
	endtask

	task automatic rand_struct(input logic f);
		logic [7:0] t;
		logic [7:0] len;
		int pick;
		pick = $urandom_range(0, 99);
		t = ($urandom_range(0, 3) == 0) ? target_sel : 8'($urandom);
		if (pick < 8)
			len = 8'($urandom_range(0, 3));
		else if (pick < 10)
			len = 8'($urandom_range(200, 255));
		else if (pick < 20)
			len = 8'($urandom_range(17, 40));
		else
			len = 8'($urandom_range(4, 16));
		send_struct(t, len, $urandom_range(0, 3), f);
	endtask

	task automatic random_phase(input int items);
		int stop_at;
		int pick;
		stop_at = bytes_sent + items;
		rand_struct(1'b1);
		while (bytes_sent < stop_at) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				rand_struct(1'b0);
			end else if (pick < 88) begin
				rand_struct(1'b1);
			end else if (pick < 96) begin
				// stray bytes knock the parse out of step
				repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
			end else begin
				// a new walk that starts with a truncated header
				send_byte(8'($urandom), 1'b1);
				send_byte(8'($urandom_range(4, 20)), 1'b0);
				repeat ($urandom_range(0, 3)) send_byte(8'($urandom), 1'b0);
			end
		end
	endtask

	initial begin
		logic [15:0] so;
		in_valid <= 1'b0;
		data_byte <= 8'h00;
		first_byte <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= CFG_TARGET_TYPE;
		cfg_data <= '0;
		sender_steady = 1'b0;
		sink_steady = 1'b0;
		hold_req = 1'b0;
		bytes_sent = 0;
		target_sel = 8'h00;
		@(posedge arst_n);
		@(posedge clk);

		// no walk started yet: offsets from zero, nothing skipped
		configure(8'hFF, 1'b0, 1'b0, 16'h0000, 16'hFFFF);
		send_struct(8'hFF, 8'd4, 0, 1'b0);
		settle();

		// resumed walk: first structure never matches; short headers
		configure(8'hFF, 1'b0, 1'b1, 16'h0120, 16'hFFFF);
		send_struct(8'hFF, 8'd0, 0, 1'b1);
		send_struct(8'hFF, 8'd3, 1, 1'b0);
		send_struct(8'h00, 8'd5, 2, 1'b0);
		settle();

		// table end: second structure loses its last zero, offset pins at max
		configure(8'h00, 1'b1, 1'b0, 16'hFFF4, 16'hFFFF);
		send_struct(8'h00, 8'd4, 0, 1'b1);
		send_struct(8'hFF, 8'd4, 0, 1'b0);
		repeat (2) send_byte(8'h00, 1'b0);
		settle();

		// empty table: every byte dropped
		configure(8'h00, 1'b0, 1'b0, 16'hFFFF, 16'h0000);
		send_struct(8'h00, 8'd4, 0, 1'b1);
		settle();

		// back-to-back, no stalls on either side
		sender_steady = 1'b1;
		sink_steady = 1'b1;
		configure(8'($urandom), 1'b0, 1'b0, 16'h0000, 16'hFFFF);
		random_phase(PHASE_ITEMS);
		settle();
		sender_steady = 1'b0;
		sink_steady = 1'b0;

		configure(8'h00, 1'b0, 1'b1, 16'($urandom_range(0, 1000)), 16'hFFFF);
		random_phase(PHASE_ITEMS);
		settle();

		// sink holds off while the sender keeps pushing bytes
		sender_steady = 1'b1;
		hold_req = 1'b1;
		configure(8'hFF, 1'b1, 1'b1, 16'($urandom_range(0, 1000)), 16'hFFFF);
		random_phase(PHASE_ITEMS);
		settle();
		sender_steady = 1'b0;

		so = 16'($urandom_range(0, 2000));
		configure(8'($urandom), 1'($urandom), 1'($urandom), so,
			so + 16'($urandom_range(100, 400)));
		random_phase(PHASE_ITEMS);
		settle();

		configure(8'($urandom), 1'b0, 1'b0, 16'hFF00, 16'hFFFF);
		random_phase(PHASE_ITEMS);
		settle();

		configure(8'($urandom), 1'($urandom), 1'($urandom),
			16'($urandom_range(0, 30000)), 16'hFFFF);
		random_phase(PHASE_ITEMS);
		settle();

		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
